// File: rtl/rsa_pkg.sv
// rsa_pkg: shared constants, command codes and controller/datapath bundles
// for the record slot allocator. No dependencies.
package rsa_pkg;

   localparam int SLOTS        = 1024;
   localparam int SLOT_W       = $clog2(SLOTS);
   localparam int COUNT_W      = $clog2(SLOTS + 1);
   localparam int RECORD_WIDTH = 64;
   localparam int CMD_W        = 2;

   // stream word widths, padded to whole bytes
   localparam int REQ_DATA_W = 80;   // slot(10) record_in(64) pad(6)
   localparam int RSP_DATA_W = 88;   // slot_out(10) record_out(64) free_left(11) pad(3)

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_INIT   = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic accept;      // latch request, launch memory reads
      logic exec;        // apply add/delete/read, load result
      logic sweep_step;  // clear one in-use bit, advance index
      logic sweep_fill;  // also write the free stack on this step
      logic finish;      // load initialize result
   } rsa_ctrl_type;

   // datapath -> controller
   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic             sweep_last;
      logic             out_free;
   } rsa_status_type;

endpackage

// File: rtl/rsa_ctrl.sv
// rsa_ctrl: sequencing state machine of the record slot allocator.
// Depends on rsa_pkg for command codes and the control/status bundles.
module rsa_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  rsa_pkg::rsa_status_type status,
   output rsa_pkg::rsa_ctrl_type   ctrl
);

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_EXEC   = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in        = state_ff;
      ctrl            = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctrl.sweep_step = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               ctrl.accept = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (status.cmd == rsa_pkg::CMD_INIT) begin
               state_in = ST_SWEEP;
            end else if (status.out_free) begin
               ctrl.exec = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_SWEEP: begin
            ctrl.sweep_step = 1'b1;
            ctrl.sweep_fill = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               ctrl.finish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

// File: rtl/rsa_datapath.sv
// rsa_datapath: slot memories, free stack, counters and result register.
// Depends on rsa_pkg; driven by rsa_ctrl through the control bundle.
module rsa_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [rsa_pkg::COUNT_W-1:0]         csr_wr_data,
   input  logic [rsa_pkg::CMD_W-1:0]           req_cmd,
   input  logic [rsa_pkg::SLOT_W-1:0]          req_slot,
   input  logic [rsa_pkg::RECORD_WIDTH-1:0]    req_record,
   input  rsa_pkg::rsa_ctrl_type               ctrl,
   output rsa_pkg::rsa_status_type             status,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic                                rsp_ok,
   output logic [rsa_pkg::SLOT_W-1:0]          rsp_slot,
   output logic [rsa_pkg::RECORD_WIDTH-1:0]    rsp_record,
   output logic [rsa_pkg::COUNT_W-1:0]         rsp_free_left
);

   localparam logic [rsa_pkg::COUNT_W-1:0] SLOTS_C = rsa_pkg::COUNT_W'(rsa_pkg::SLOTS);
   localparam logic [rsa_pkg::SLOT_W-1:0]  LAST_IDX = rsa_pkg::SLOT_W'(rsa_pkg::SLOTS - 1);

   // memories
   logic [rsa_pkg::SLOT_W-1:0]       stack_mem [rsa_pkg::SLOTS];
   logic                             use_mem   [rsa_pkg::SLOTS];
   logic [rsa_pkg::RECORD_WIDTH-1:0] rec_mem   [rsa_pkg::SLOTS];

   logic [rsa_pkg::SLOT_W-1:0]       stack_rd_ff;
   logic                             use_rd_ff;
   logic [rsa_pkg::RECORD_WIDTH-1:0] rec_rd_ff;

   // config and control state
   logic [rsa_pkg::COUNT_W-1:0] slot_count_ff;
   logic [rsa_pkg::COUNT_W-1:0] free_count_ff;
   logic [rsa_pkg::COUNT_W-1:0] free_count_in;
   logic [rsa_pkg::SLOT_W-1:0]  sweep_idx_ff;
   logic                        rsp_valid_ff;

   // latched item
   logic [rsa_pkg::CMD_W-1:0]        cmd_ff;
   logic [rsa_pkg::SLOT_W-1:0]       slot_ff;
   logic [rsa_pkg::RECORD_WIDTH-1:0] rec_ff;
   logic [rsa_pkg::COUNT_W-1:0]      cnt_ff;
   logic [rsa_pkg::COUNT_W-1:0]      cnt_in;

   // result payload
   logic                             ok_ff,   ok_in;
   logic [rsa_pkg::SLOT_W-1:0]       slot_out_ff, slot_out_in;
   logic [rsa_pkg::RECORD_WIDTH-1:0] rec_out_ff,  rec_out_in;
   logic [rsa_pkg::COUNT_W-1:0]      free_out_ff;

   // memory write controls
   logic                             use_we, use_wd;
   logic [rsa_pkg::SLOT_W-1:0]       use_wa;
   logic                             rec_we;
   logic                             stack_we;
   logic [rsa_pkg::SLOT_W-1:0]       stack_wa, stack_wd;
   logic [rsa_pkg::COUNT_W-1:0]      fill_addr;
   logic [rsa_pkg::SLOT_W-1:0]       pop_addr;
   logic                             hit;
   logic                             rsp_load;

   assign cnt_in   = (slot_count_ff > SLOTS_C) ? SLOTS_C : slot_count_ff;
   assign pop_addr = rsa_pkg::SLOT_W'(free_count_ff - rsa_pkg::COUNT_W'(1));
   assign fill_addr = cnt_ff - rsa_pkg::COUNT_W'(1) - {1'b0, sweep_idx_ff};
   assign hit      = ({1'b0, slot_ff} < cnt_ff) && use_rd_ff;
   assign rsp_load = ctrl.exec || ctrl.finish;

   always_comb begin
      free_count_in = free_count_ff;
      ok_in         = 1'b0;
      slot_out_in   = '0;
      rec_out_in    = '0;
      use_we        = 1'b0;
      use_wa        = sweep_idx_ff;
      use_wd        = 1'b0;
      rec_we        = 1'b0;
      stack_we      = 1'b0;
      stack_wa      = fill_addr[rsa_pkg::SLOT_W-1:0];
      stack_wd      = sweep_idx_ff;
      if (ctrl.exec) begin
         unique case (cmd_ff)
            rsa_pkg::CMD_ADD: begin
               if (free_count_ff != '0) begin
                  free_count_in = free_count_ff - rsa_pkg::COUNT_W'(1);
                  ok_in         = 1'b1;
                  slot_out_in   = stack_rd_ff;
                  use_we        = 1'b1;
                  use_wa        = stack_rd_ff;
                  use_wd        = 1'b1;
                  rec_we        = 1'b1;
               end
            end
            rsa_pkg::CMD_DELETE: begin
               if (hit) begin
                  ok_in      = 1'b1;
                  rec_out_in = rec_rd_ff;
                  use_we     = 1'b1;
                  use_wa     = slot_ff;
                  if (free_count_ff < SLOTS_C) begin
                     stack_we      = 1'b1;
                     stack_wa      = free_count_ff[rsa_pkg::SLOT_W-1:0];
                     stack_wd      = slot_ff;
                     free_count_in = free_count_ff + rsa_pkg::COUNT_W'(1);
                  end
               end
            end
            rsa_pkg::CMD_READ: begin
               if (hit) begin
                  ok_in      = 1'b1;
                  rec_out_in = rec_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
      if (ctrl.sweep_step) begin
         use_we = 1'b1;
         if (ctrl.sweep_fill && ({1'b0, sweep_idx_ff} < cnt_ff)) begin
            stack_we = 1'b1;
         end
      end
      if (ctrl.finish) begin
         ok_in         = 1'b1;
         free_count_in = cnt_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_count_ff <= SLOTS_C;
         free_count_ff <= '0;
         sweep_idx_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            slot_count_ff <= csr_wr_data;
         end
         free_count_ff <= free_count_in;
         if (ctrl.sweep_step) begin
            sweep_idx_ff <= sweep_idx_ff + rsa_pkg::SLOT_W'(1);
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         cmd_ff  <= req_cmd;
         slot_ff <= req_slot;
         rec_ff  <= req_record;
         cnt_ff  <= cnt_in;
      end
      if (rsp_load) begin
         ok_ff       <= ok_in;
         slot_out_ff <= slot_out_in;
         rec_out_ff  <= rec_out_in;
         free_out_ff <= free_count_in;
      end
   end

   // free stack
   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[stack_wa] <= stack_wd;
      end
      if (ctrl.accept) begin
         stack_rd_ff <= stack_mem[pop_addr];
      end
   end

   // in-use map
   always_ff @(posedge clock) begin
      if (use_we) begin
         use_mem[use_wa] <= use_wd;
      end
      if (ctrl.accept) begin
         use_rd_ff <= use_mem[req_slot];
      end
   end

   // record store
   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[stack_rd_ff] <= rec_ff;
      end
      if (ctrl.accept) begin
         rec_rd_ff <= rec_mem[req_slot];
      end
   end

   assign status.cmd        = cmd_ff;
   assign status.sweep_last = (sweep_idx_ff == LAST_IDX);
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid    = rsp_valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_slot      = slot_out_ff;
   assign rsp_record    = rec_out_ff;
   assign rsp_free_left = free_out_ff;

endmodule

// File: rtl/record_slot_allocator.sv
// record_slot_allocator: top level, free-list stack allocator over a fixed
// table of record slots. Depends on rsa_pkg, rsa_ctrl and rsa_datapath.
//
//   port group  dir  word                               meaning
//   req_*       in   tuser: command[1:0]                one command word
//                    tdata: slot[9:0] record_in[73:10]
//   rsp_*       out  tuser: ok[0]                       one result per command
//                    tdata: slot_out[9:0] record_out[73:10] free_left[84:74]
//   csr_*       in   wr_data: slot_count[10:0]          slot count, no read-back
//
// Add, delete and read run as accept plus memory read, then update; the update
// waits while a stalled result still holds the output register. Initialize runs
// accept, decode, a sweep of the single write port of the in-use map over all
// slots while the free stack is refilled alongside, then a step to load the result.
// After reset a clearing pass of the in-use map over all slots runs with
// req_tready low. One command is in flight at a time; a result stalled on
// rsp_tready holds in the output register and the next command is still taken.
module record_slot_allocator (
   input  logic                              clock,
   input  logic                              reset,
   // command channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [rsa_pkg::REQ_DATA_W-1:0]    req_tdata,  // slot[9:0], record_in[73:10], zero pad
   input  logic [rsa_pkg::CMD_W-1:0]         req_tuser,  // command[1:0]
   // result channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [rsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // slot_out[9:0], record_out[73:10],
                                                         // free_left[84:74], zero pad
   output logic                              rsp_tuser,  // ok[0]
   // configuration
   input  logic                              csr_wr_en,
   input  logic [rsa_pkg::COUNT_W-1:0]       csr_wr_data // slot_count
);

   localparam int PAD_W = rsa_pkg::RSP_DATA_W - rsa_pkg::SLOT_W
                          - rsa_pkg::RECORD_WIDTH - rsa_pkg::COUNT_W;

   rsa_pkg::rsa_ctrl_type   ctrl;
   rsa_pkg::rsa_status_type status;

   logic                             rsp_ok;
   logic [rsa_pkg::SLOT_W-1:0]       rsp_slot;
   logic [rsa_pkg::RECORD_WIDTH-1:0] rsp_record;
   logic [rsa_pkg::COUNT_W-1:0]      rsp_free_left;

   // sequencing
   rsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   // memories, counters, result register
   rsa_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_cmd       (req_tuser),
      .req_slot      (req_tdata[rsa_pkg::SLOT_W-1:0]),
      .req_record    (req_tdata[rsa_pkg::SLOT_W +: rsa_pkg::RECORD_WIDTH]),
      .ctrl          (ctrl),
      .status        (status),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_ok        (rsp_ok),
      .rsp_slot      (rsp_slot),
      .rsp_record    (rsp_record),
      .rsp_free_left (rsp_free_left)
   );

   // pack result word, first field lowest
   assign rsp_tdata = {{PAD_W{1'b0}}, rsp_free_left, rsp_record, rsp_slot};
   assign rsp_tuser = rsp_ok;

endmodule

// File: rtl/rsa_checker.sv
// rsa_checker: port-level assertions for the record slot allocator, bound
// to the top level. Depends on rsa_pkg for word layout.
module rsa_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   localparam int FREE_LO = rsa_pkg::SLOT_W + rsa_pkg::RECORD_WIDTH;

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // one command in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("command taken while previous still in progress");

   // failed command returns zero slot and record
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[FREE_LO-1:0] == '0)
      else $error("failed result carries slot or record data");

   // free count never exceeds the table
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         rsp_tdata[FREE_LO +: rsa_pkg::COUNT_W] <= rsa_pkg::COUNT_W'(rsa_pkg::SLOTS))
      else $error("free_left beyond slot count");

endmodule

bind record_slot_allocator rsa_checker u_rsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
